// File: rtl/tfsi_pkg.sv
// Shared types, constants and register codes for the tilt filter and shake impulse core.
package tfsi_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int SQRT_CYCLES_DEF   = (SAMPLE_WIDTH_DEF + 3) / 2;

    localparam int IMPULSE_W   = 14;
    localparam int GRAVITY_W   = 14;
    localparam int STRENGTH_W  = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int ALPHA_W = 17;
    localparam int DECAY_W = 16;
    localparam int THR_W   = 15;
    localparam int GAIN_W  = 4;
    localparam int CEIL_W  = 14;
    localparam int FLOOR_W = 12;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd8738;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd62836;
    localparam logic [THR_W-1:0]   THR_RESET   = 15'd5325;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd4;
    localparam logic [CEIL_W-1:0]  CEIL_RESET  = 14'd10240;
    localparam logic [CEIL_W-1:0]  MCEIL_RESET = 14'd12288;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 12'd41;

    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 17'd655;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 17'd65536;

    // Q1.16 alpha and Q0.16 decay factors are applied with a 16-bit right shift.
    localparam int GAIN_SHIFT = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA       = 3'd0,
        REG_DECAY       = 3'd1,
        REG_THRESHOLD   = 3'd2,
        REG_GAIN        = 3'd3,
        REG_CEILING     = 3'd4,
        REG_MANUAL_CEIL = 3'd5,
        REG_FLOOR       = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [DECAY_W-1:0] decay;
        logic [THR_W-1:0]   thr;
        logic [GAIN_W-1:0]  gain;
        logic [CEIL_W-1:0]  ceil;
        logic [CEIL_W-1:0]  mceil;
        logic [FLOOR_W-1:0] floor_lvl;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_DX    = 3'd0,
        MUL_DY    = 3'd1,
        MUL_DZ    = 3'd2,
        MUL_THR   = 3'd3,
        MUL_FX    = 3'd4,
        MUL_FY    = 3'd5,
        MUL_GAIN  = 3'd6,
        MUL_DECAY = 3'd7
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_DX     = 4'd1,
        ST_DY     = 4'd2,
        ST_DZ     = 4'd3,
        ST_THR    = 4'd4,
        ST_FX     = 4'd5,
        ST_FY     = 4'd6,
        ST_FYU    = 4'd7,
        ST_SQRT   = 4'd8,
        ST_GAIN   = 4'd9,
        ST_SAT    = 4'd10,
        ST_DECAY  = 4'd11,
        ST_FLOOR  = 4'd12,
        ST_MANUAL = 4'd13,
        ST_OUT    = 4'd14
    } ctrl_state_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     acc_first;
        logic     det_cap;
        logic     filt_x;
        logic     filt_y;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     imp_sat;
        logic     imp_floor;
        logic     imp_manual;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic manual;
        logic shake;
    } dp_status_t;

endpackage

// File: rtl/tfsi_cfg.sv
// Configuration register file written through the valid/ready configuration channel.
module tfsi_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tfsi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tfsi_pkg::CFG_DATA_W-1:0]      cfg_data,
    output tfsi_pkg::cfg_t                       cfg
);
    import tfsi_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_ALPHA:       cfg_next.alpha     = cfg_data[ALPHA_W-1:0];
                REG_DECAY:       cfg_next.decay     = cfg_data[DECAY_W-1:0];
                REG_THRESHOLD:   cfg_next.thr       = cfg_data[THR_W-1:0];
                REG_GAIN:        cfg_next.gain      = cfg_data[GAIN_W-1:0];
                REG_CEILING:     cfg_next.ceil      = cfg_data[CEIL_W-1:0];
                REG_MANUAL_CEIL: cfg_next.mceil     = cfg_data[CEIL_W-1:0];
                REG_FLOOR:       cfg_next.floor_lvl = cfg_data[FLOOR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha     <= ALPHA_RESET;
            cfg_reg.decay     <= DECAY_RESET;
            cfg_reg.thr       <= THR_RESET;
            cfg_reg.gain      <= GAIN_RESET;
            cfg_reg.ceil      <= CEIL_RESET;
            cfg_reg.mceil     <= MCEIL_RESET;
            cfg_reg.floor_lvl <= FLOOR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/tfsi_ctrl.sv
// Sequencer that steps the shared multiplier, root unit and impulse update for each word.
module tfsi_ctrl #(
    parameter int SQRT_CYCLES = tfsi_pkg::SQRT_CYCLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tfsi_pkg::dp_cmd_t     cmd,
    input  tfsi_pkg::dp_status_t  status
);
    import tfsi_pkg::*;

    localparam int CW = $clog2(SQRT_CYCLES);

    ctrl_state_t     state_reg;
    ctrl_state_t     state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DX;
            ST_DX:     state_next = status.manual ? ST_MANUAL : ST_DY;
            ST_DY:     state_next = ST_DZ;
            ST_DZ:     state_next = ST_THR;
            ST_THR:    state_next = ST_FX;
            ST_FX:     state_next = ST_FY;
            ST_FY:     state_next = ST_FYU;
            ST_FYU:    state_next = status.shake ? ST_SQRT : ST_DECAY;
            ST_SQRT:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SQRT_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:   state_next = ST_SAT;
            ST_SAT:    state_next = ST_DECAY;
            ST_DECAY:  state_next = ST_FLOOR;
            ST_FLOOR:  state_next = ST_OUT;
            ST_MANUAL: state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_DX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
            end
            ST_DY:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DY;
                cmd.acc_en    = 1'b1;
                cmd.acc_first = 1'b1;
            end
            ST_DZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DZ;
                cmd.acc_en  = 1'b1;
            end
            ST_THR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_THR;
                cmd.acc_en  = 1'b1;
            end
            ST_FX:
            begin
                cmd.det_cap = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FX;
            end
            ST_FY:
            begin
                cmd.filt_x  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FY;
            end
            ST_FYU:
            begin
                cmd.filt_y    = 1'b1;
                cmd.sqrt_init = 1'b1;
            end
            ST_SQRT:   cmd.sqrt_step = 1'b1;
            ST_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
            end
            ST_SAT:    cmd.imp_sat = 1'b1;
            ST_DECAY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DECAY;
            end
            ST_FLOOR:  cmd.imp_floor = 1'b1;
            ST_MANUAL: cmd.imp_manual = 1'b1;
            ST_OUT:    cmd.out_load = out_free;
            default:   cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DX))
        else $error("accepted word did not start the sequence");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> (cnt_reg <= CW'(SQRT_CYCLES - 1)))
        else $error("root iteration count overran");

endmodule

// File: rtl/tfsi_dp.sv
// Datapath: input latch, filter and impulse state, shared multiplier, root unit, result register.
module tfsi_dp #(
    parameter int SAMPLE_WIDTH  = tfsi_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = tfsi_pkg::FRACTION_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  tfsi_pkg::cfg_t                             cfg,
    input  tfsi_pkg::dp_cmd_t                          cmd,
    output tfsi_pkg::dp_status_t                       status,
    input  logic                                       action,
    input  logic signed [SAMPLE_WIDTH-1:0]             accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]             accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]             accel_z,
    input  logic signed [tfsi_pkg::STRENGTH_W-1:0]     trigger_strength,
    output logic signed [tfsi_pkg::GRAVITY_W-1:0]      gravity_x,
    output logic signed [tfsi_pkg::GRAVITY_W-1:0]      gravity_y,
    output logic [tfsi_pkg::IMPULSE_W-1:0]             shake_impulse,
    output logic                                       shake_detected
);
    import tfsi_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int FW     = FRACTION_BITS + 2;
    localparam int AW0    = (SW + 4 > FRACTION_BITS + 3) ? SW + 4 : FRACTION_BITS + 3;
    localparam int AW     = (AW0 > 18) ? AW0 : 18;
    localparam int PW     = 2 * AW;
    localparam int SQ_CYC = (SW + 3) / 2;
    localparam int RB     = 2 * SQ_CYC;
    localparam int EW     = 2 * RB;
    localparam int REMW   = RB + 3;
    localparam int MSW    = IMPULSE_W + 3;

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (GAIN_SHIFT - 1);
    localparam logic signed [PW-1:0] ONE_G_POS  = PW'(1) <<< FRACTION_BITS;
    localparam logic signed [PW-1:0] ONE_G_NEG  = -ONE_G_POS;

    // Latched input word and persistent state.
    logic                          action_reg;
    logic signed [SW-1:0]          ax_reg, ay_reg, az_reg;
    logic signed [STRENGTH_W-1:0]  strength_reg;
    logic signed [SW-1:0]          px_reg, py_reg, pz_reg;
    logic signed [FW-1:0]          fx_reg, fy_reg;
    logic signed [FW-1:0]          fx_next, fy_next;
    logic [IMPULSE_W-1:0]          imp_reg, imp_next;
    logic                          det_reg, det_next;

    // Working registers.
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic [EW-1:0]                 acc_reg, acc_next;
    logic [EW-1:0]                 rad_reg, rad_next;
    logic [REMW-1:0]               rem_reg, rem_next;
    logic [RB-1:0]                 root_reg, root_next;

    // Result register.
    logic signed [GRAVITY_W-1:0]   gx_out_reg, gy_out_reg;
    logic [IMPULSE_W-1:0]          imp_out_reg;
    logic                          det_out_reg;

    // Multiplier operands.
    logic signed [AW-1:0]          ax_e, ay_e, az_e, px_e, py_e, pz_e;
    logic signed [AW-1:0]          fx_e, fy_e, thr_e, alpha_e, gain_e, root_e;
    logic signed [AW-1:0]          imp_e, decay_e;
    logic signed [AW-1:0]          op_a, op_b;
    logic [ALPHA_W-1:0]            alpha_use;

    // Filter update.
    logic signed [FW-1:0]          f_sel;
    logic signed [PW-1:0]          f_pw, f_rnd, f_step, f_sum, f_clamp;
    logic signed [PW-1:0]          fx_pw, fy_pw;

    // Impulse arithmetic.
    logic [PW-1:0]                 sat_sum, ceil_pw, thr_sq;
    logic [IMPULSE_W-1:0]          dec_val;
    logic signed [MSW-1:0]         man_sum;

    // Root iteration.
    logic [REMW-1:0]               rem_v, trial;
    logic [RB-1:0]                 root_v;
    logic [EW-1:0]                 rad_v;

    assign alpha_use = (cfg.alpha < ALPHA_MIN) ? ALPHA_MIN :
                       ((cfg.alpha > ALPHA_MAX) ? ALPHA_MAX : cfg.alpha);

    assign ax_e    = {{(AW-SW){ax_reg[SW-1]}}, ax_reg};
    assign ay_e    = {{(AW-SW){ay_reg[SW-1]}}, ay_reg};
    assign az_e    = {{(AW-SW){az_reg[SW-1]}}, az_reg};
    assign px_e    = {{(AW-SW){px_reg[SW-1]}}, px_reg};
    assign py_e    = {{(AW-SW){py_reg[SW-1]}}, py_reg};
    assign pz_e    = {{(AW-SW){pz_reg[SW-1]}}, pz_reg};
    assign fx_e    = {{(AW-FW){fx_reg[FW-1]}}, fx_reg};
    assign fy_e    = {{(AW-FW){fy_reg[FW-1]}}, fy_reg};
    assign thr_e   = {{(AW-THR_W){1'b0}}, cfg.thr};
    assign alpha_e = {{(AW-ALPHA_W){1'b0}}, alpha_use};
    assign gain_e  = {{(AW-GAIN_W){1'b0}}, cfg.gain};
    assign root_e  = {{(AW-RB){1'b0}}, root_reg};
    assign imp_e   = {{(AW-IMPULSE_W){1'b0}}, imp_reg};
    assign decay_e = {{(AW-DECAY_W){1'b0}}, cfg.decay};

    always_comb
    begin
        op_a = ax_e - px_e;
        op_b = ax_e - px_e;
        case (cmd.mul_sel)
            MUL_DX:
            begin
                op_a = ax_e - px_e;
                op_b = ax_e - px_e;
            end
            MUL_DY:
            begin
                op_a = ay_e - py_e;
                op_b = ay_e - py_e;
            end
            MUL_DZ:
            begin
                op_a = az_e - pz_e;
                op_b = az_e - pz_e;
            end
            MUL_THR:
            begin
                op_a = thr_e;
                op_b = thr_e;
            end
            // Screen X follows the sensor Y axis and screen Y the sensor X axis.
            MUL_FX:
            begin
                op_a = ay_e - fx_e;
                op_b = alpha_e;
            end
            MUL_FY:
            begin
                op_a = ax_e - fy_e;
                op_b = alpha_e;
            end
            MUL_GAIN:
            begin
                op_a = gain_e;
                op_b = root_e - thr_e;
            end
            MUL_DECAY:
            begin
                op_a = imp_e;
                op_b = decay_e;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = cmd.mul_en ? (op_a * op_b) : prod_reg;

    assign acc_next = !cmd.acc_en   ? acc_reg :
                      cmd.acc_first ? prod_reg[EW-1:0] :
                                      acc_reg + prod_reg[EW-1:0];

    // The multiplier holds the squared threshold while the jerk energy is compared.
    assign thr_sq   = prod_reg;
    assign det_next = cmd.load_in ? 1'b0 :
                      cmd.det_cap ? ({{(PW-EW){1'b0}}, acc_reg} > thr_sq) : det_reg;

    // Round to nearest with ties upward, then clamp to one g.
    assign f_sel   = cmd.filt_y ? fy_reg : fx_reg;
    assign f_pw    = {{(PW-FW){f_sel[FW-1]}}, f_sel};
    assign f_rnd   = prod_reg + ROUND_HALF;
    assign f_step  = f_rnd >>> GAIN_SHIFT;
    assign f_sum   = f_pw + f_step;
    assign f_clamp = (f_sum > ONE_G_POS) ? ONE_G_POS :
                     ((f_sum < ONE_G_NEG) ? ONE_G_NEG : f_sum);

    assign fx_next = cmd.filt_x ? f_clamp[FW-1:0] : fx_reg;
    assign fy_next = cmd.filt_y ? f_clamp[FW-1:0] : fy_reg;

    // Two result bits of the integer root per cycle.
    always_comb
    begin
        rem_v  = rem_reg;
        root_v = root_reg;
        rad_v  = rad_reg;
        trial  = '0;
        for (int i = 0; i < 2; i++)
        begin
            rem_v = {rem_v[REMW-3:0], rad_v[EW-1 -: 2]};
            rad_v = {rad_v[EW-3:0], 2'b00};
            trial = {{(REMW-RB-2){1'b0}}, root_v, 2'b01};
            if (rem_v >= trial)
            begin
                rem_v  = rem_v - trial;
                root_v = {root_v[RB-2:0], 1'b1};
            end
            else
            begin
                root_v = {root_v[RB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (cmd.sqrt_init)
        begin
            rad_next  = acc_reg;
            rem_next  = '0;
            root_next = '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_next  = rad_v;
            rem_next  = rem_v;
            root_next = root_v;
        end
    end

    assign ceil_pw = {{(PW-CEIL_W){1'b0}}, cfg.ceil};
    assign sat_sum = {{(PW-IMPULSE_W){1'b0}}, imp_reg} + $unsigned(prod_reg);
    assign dec_val = prod_reg[GAIN_SHIFT +: IMPULSE_W];
    assign man_sum = $signed({{(MSW-IMPULSE_W){1'b0}}, imp_reg})
                   + {{(MSW-STRENGTH_W){strength_reg[STRENGTH_W-1]}}, strength_reg};

    always_comb
    begin
        imp_next = imp_reg;
        if (cmd.imp_sat)
        begin
            imp_next = (sat_sum > ceil_pw) ? cfg.ceil : sat_sum[IMPULSE_W-1:0];
        end
        else if (cmd.imp_floor)
        begin
            imp_next = (dec_val < {{(IMPULSE_W-FLOOR_W){1'b0}}, cfg.floor_lvl}) ? '0 : dec_val;
        end
        else if (cmd.imp_manual)
        begin
            if (man_sum < 0)
                imp_next = '0;
            else if (man_sum > $signed({{(MSW-CEIL_W){1'b0}}, cfg.mceil}))
                imp_next = cfg.mceil;
            else
                imp_next = man_sum[IMPULSE_W-1:0];
        end
    end

    assign fx_pw = {{(PW-FW){fx_reg[FW-1]}}, fx_reg};
    assign fy_pw = {{(PW-FW){fy_reg[FW-1]}}, fy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg  <= '0;
            py_reg  <= '0;
            pz_reg  <= '0;
            fx_reg  <= '0;
            fy_reg  <= '0;
            imp_reg <= '0;
            det_reg <= 1'b0;
        end
        else
        begin
            if (cmd.filt_y)
            begin
                px_reg <= ax_reg;
                py_reg <= ay_reg;
                pz_reg <= az_reg;
            end
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
            imp_reg <= imp_next;
            det_reg <= det_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg   <= action;
            ax_reg       <= accel_x;
            ay_reg       <= accel_y;
            az_reg       <= accel_z;
            strength_reg <= trigger_strength;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (cmd.out_load)
        begin
            gx_out_reg  <= fx_pw[GRAVITY_W-1:0];
            gy_out_reg  <= fy_pw[GRAVITY_W-1:0];
            imp_out_reg <= imp_reg;
            det_out_reg <= det_reg;
        end
    end

    assign status.manual  = action_reg;
    assign status.shake   = det_reg;
    assign gravity_x      = gx_out_reg;
    assign gravity_y      = gy_out_reg;
    assign shake_impulse  = imp_out_reg;
    assign shake_detected = det_out_reg;

endmodule

// File: rtl/tilt_filter_and_shake_impulse_core.sv
// Top level of the tilt filter and shake impulse core.
// Each accepted word is handled on its own by a sequencer driving one shared signed
// multiplier, so a new word is taken only after the sequencer is through with the last
// one. A sensor sample makes seven multiplier passes (three squares, the squared
// threshold, two filter products and the decay product), plus the gain product and the
// integer root, which yields two bits per cycle, when a shake is seen. A finished result
// sits in an output register, so the next word is taken while it waits for out_ready.
// Configuration writes are always accepted and are registered.
module tilt_filter_and_shake_impulse_core #(
    parameter int SAMPLE_WIDTH  = tfsi_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = tfsi_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    action,
    input  logic signed [SAMPLE_WIDTH-1:0]          accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]          accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]          accel_z,
    input  logic signed [tfsi_pkg::STRENGTH_W-1:0]  trigger_strength,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [tfsi_pkg::GRAVITY_W-1:0]   gravity_x,
    output logic signed [tfsi_pkg::GRAVITY_W-1:0]   gravity_y,
    output logic [tfsi_pkg::IMPULSE_W-1:0]          shake_impulse,
    output logic                                    shake_detected,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tfsi_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [tfsi_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import tfsi_pkg::*;

    localparam int SQRT_CYCLES = (SAMPLE_WIDTH + 3) / 2;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tfsi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tfsi_ctrl #(
        .SQRT_CYCLES (SQRT_CYCLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tfsi_dp #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .trigger_strength (trigger_strength),
        .gravity_x        (gravity_x),
        .gravity_y        (gravity_y),
        .shake_impulse    (shake_impulse),
        .shake_detected   (shake_detected)
    );

endmodule
